FILE: hdl/assert_macros.svh
// Assertion helpers; compiled out under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MSP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define MSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define MSP_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define MSP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/msp_pkg.sv
`default_nettype none

package msp_pkg;

   localparam int unsigned MOTOR_COUNT = 4;

   // speed percent in percent*256 units: |speed| * 100 * 256
   localparam int unsigned PCT_SCALE = 100 * 256;

   localparam int unsigned LIMIT_W = 15;
   localparam int unsigned DEV_W   = 16;
   localparam int unsigned TICKS_W = 8;
   localparam int unsigned PROD_W  = 30;
   localparam int unsigned SLACK_W = LIMIT_W + DEV_W;
   localparam int unsigned ADDR_W  = 4;

   localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST   = 15'd256;
   localparam logic [DEV_W-1:0]   DEVIATION_RST     = 16'd2560;
   localparam logic [TICKS_W-1:0] OVERSPEED_TKS_RST = 8'd5;
   localparam logic [TICKS_W-1:0] MISMATCH_TKS_RST  = 8'd5;

   typedef enum logic [1:0] {
      CSR_SPEED_LIMIT    = 2'd0,
      CSR_ALLOWED_DEV    = 2'd1,
      CSR_OVERSPEED_TKS  = 2'd2,
      CSR_MISMATCH_TKS   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic neg;
      logic over;
      logic mism;
   } lane_flags_type;

endpackage

`default_nettype wire

FILE: hdl/msp_req_if.sv
`default_nettype none

interface msp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] speed_motor0;
   logic signed [15:0] speed_motor1;
   logic signed [15:0] speed_motor2;
   logic signed [15:0] speed_motor3;
   logic signed [15:0] power_motor0;
   logic signed [15:0] power_motor1;
   logic signed [15:0] power_motor2;
   logic signed [15:0] power_motor3;

   modport source (
      output valid, speed_motor0, speed_motor1, speed_motor2, speed_motor3,
             power_motor0, power_motor1, power_motor2, power_motor3,
      input  ready
   );

   modport sink (
      input  valid, speed_motor0, speed_motor1, speed_motor2, speed_motor3,
             power_motor0, power_motor1, power_motor2, power_motor3,
      output ready
   );
endinterface

interface msp_rsp_if;
   logic valid;
   logic ready;
   logic speed_report;
   logic speed_danger;
   logic power_report;
   logic power_danger;

   modport source (
      output valid, speed_report, speed_danger, power_report, power_danger,
      input  ready
   );

   modport sink (
      input  valid, speed_report, speed_danger, power_report, power_danger,
      output ready
   );
endinterface

`default_nettype wire

FILE: hdl/motor_speed_power_monitor.sv
`default_nettype none

// Motor speed/power monitor. Takes one tick beat per clock unless stalled
// (speed and power of four motors) and returns one report beat per tick: one
// lane per motor forms the cross-multiplied products, then compares against
// the deviation slack, and a merge stage scans the lanes up to the first
// reversed motor and runs the over-speed and mismatch persistence counters.
// Each stage can fill while later ones stall, so a new tick is taken while a
// finished report waits. Registers sit on the APB port at byte offsets 0
// (speed_limit), 4 (allowed_deviation), 8 (overspeed_ticks) and 12
// (mismatch_ticks); write them only while no tick is in flight.
module motor_speed_power_monitor (
   input  wire logic                          clock,
   input  wire logic                          reset,
   msp_req_if.sink                            req_bus,
   msp_rsp_if.source                          rsp_bus,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [msp_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [31:0]                   pwdata,
   output      logic [31:0]                   prdata,
   output      logic                          pready
);

   logic [msp_pkg::LIMIT_W-1:0]   limit_ff;
   logic [msp_pkg::DEV_W-1:0]     dev_ff;
   logic [msp_pkg::TICKS_W-1:0]   os_tks_ff, mm_tks_ff;
   logic [msp_pkg::SLACK_W-1:0]   slack_ff, slack_in;
   msp_pkg::csr_index_type        csr_idx;
   logic                          csr_wr;

   logic                          s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   logic                          s1_load, s2_load, merge_ready;
   logic signed [15:0]            lane_spd [msp_pkg::MOTOR_COUNT];
   logic signed [15:0]            lane_pwr [msp_pkg::MOTOR_COUNT];
   msp_pkg::lane_flags_type       lane_flags [msp_pkg::MOTOR_COUNT];

   // ---------------- config registers ----------------
   assign pready  = 1'b1;
   assign csr_idx = msp_pkg::csr_index_type'(paddr[3:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= msp_pkg::SPEED_LIMIT_RST;
         dev_ff    <= msp_pkg::DEVIATION_RST;
         os_tks_ff <= msp_pkg::OVERSPEED_TKS_RST;
         mm_tks_ff <= msp_pkg::MISMATCH_TKS_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            msp_pkg::CSR_SPEED_LIMIT:   limit_ff  <= pwdata[msp_pkg::LIMIT_W-1:0];
            msp_pkg::CSR_ALLOWED_DEV:   dev_ff    <= pwdata[msp_pkg::DEV_W-1:0];
            msp_pkg::CSR_OVERSPEED_TKS: os_tks_ff <= pwdata[msp_pkg::TICKS_W-1:0];
            msp_pkg::CSR_MISMATCH_TKS:  mm_tks_ff <= pwdata[msp_pkg::TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         msp_pkg::CSR_SPEED_LIMIT:   prdata = 32'(limit_ff);
         msp_pkg::CSR_ALLOWED_DEV:   prdata = 32'(dev_ff);
         msp_pkg::CSR_OVERSPEED_TKS: prdata = 32'(os_tks_ff);
         msp_pkg::CSR_MISMATCH_TKS:  prdata = 32'(mm_tks_ff);
         default:                    prdata = '0;
      endcase
   end

   // deviation * limit, settled well before the first tick reaches compare
   assign slack_in = msp_pkg::SLACK_W'(dev_ff) * msp_pkg::SLACK_W'(limit_ff);

   always_ff @(posedge clock) begin
      slack_ff <= slack_in;
   end

   // ---------------- pipeline control ----------------
   assign s2_load       = !s2_v_ff || merge_ready;
   assign s1_load       = !s1_v_ff || s2_load;
   assign req_bus.ready = s1_load;

   always_comb begin
      s1_v_in = s1_load ? req_bus.valid : s1_v_ff;
      s2_v_in = s2_load ? s1_v_ff : s2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   // ---------------- lanes ----------------
   assign lane_spd[0] = req_bus.speed_motor0;
   assign lane_spd[1] = req_bus.speed_motor1;
   assign lane_spd[2] = req_bus.speed_motor2;
   assign lane_spd[3] = req_bus.speed_motor3;
   assign lane_pwr[0] = req_bus.power_motor0;
   assign lane_pwr[1] = req_bus.power_motor1;
   assign lane_pwr[2] = req_bus.power_motor2;
   assign lane_pwr[3] = req_bus.power_motor3;

   for (genvar g = 0; g < msp_pkg::MOTOR_COUNT; g++) begin : g_lane
      msp_lane u_lane (
         .clock       (clock),
         .load_a      (s1_load && req_bus.valid),
         .load_b      (s2_load && s1_v_ff),
         .speed       (lane_spd[g]),
         .power       (lane_pwr[g]),
         .speed_limit (limit_ff),
         .slack       (slack_ff),
         .flags       (lane_flags[g])
      );
   end

   msp_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s2_v_ff),
      .in_ready        (merge_ready),
      .lane_flags      (lane_flags),
      .overspeed_ticks (os_tks_ff),
      .mismatch_ticks  (mm_tks_ff),
      .rsp             (rsp_bus)
   );

   // ---------------- checks ----------------
   `include "assert_macros.svh"

   `MSP_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_bus.valid && req_bus.ready, s1_v_ff)
   `MSP_ASSERT_IMPLY(a_empty_s1_ready, clock, reset, !s1_v_ff, req_bus.ready)
   `MSP_ASSERT_IMPLY(a_danger_reported, clock, reset, rsp_bus.valid && rsp_bus.speed_danger, rsp_bus.speed_report)
   `MSP_ASSERT_NEXT(a_s2_drains, clock, reset, s2_v_ff && merge_ready && !s1_v_ff, !s2_v_ff)

endmodule

`default_nettype wire

FILE: hdl/msp_lane.sv
`default_nettype none

// Per-motor checks: products in the first stage, compare in the second.
module msp_lane (
   input  wire logic                               clock,
   input  wire logic                               load_a,
   input  wire logic                               load_b,
   input  wire logic signed [15:0]                 speed,
   input  wire logic signed [15:0]                 power,
   input  wire logic [msp_pkg::LIMIT_W-1:0]        speed_limit,
   input  wire logic [msp_pkg::SLACK_W-1:0]        slack,
   output      msp_pkg::lane_flags_type            flags
);

   logic [15:0]                    pwr_abs;
   logic [msp_pkg::PROD_W-1:0]     prod_s_in, prod_s_ff;
   logic [msp_pkg::PROD_W-1:0]     prod_p_in, prod_p_ff;
   logic                           neg_in, neg_ff;
   logic                           over_in, over_ff;
   logic signed [msp_pkg::PROD_W:0] diff;
   logic [msp_pkg::PROD_W:0]       diff_abs;
   msp_pkg::lane_flags_type        flags_in, flags_ff;

   // -32768 wraps to 0x8000, which is the right magnitude unsigned
   assign pwr_abs   = power[15] ? 16'(-power) : 16'(power);
   assign neg_in    = speed[15];
   assign over_in   = !speed[15] && (speed[14:0] > speed_limit);
   assign prod_s_in = msp_pkg::PROD_W'(speed[14:0]) * msp_pkg::PROD_W'(msp_pkg::PCT_SCALE);
   assign prod_p_in = msp_pkg::PROD_W'(pwr_abs) * msp_pkg::PROD_W'(speed_limit);

   always_ff @(posedge clock) begin
      if (load_a) begin
         prod_s_ff <= prod_s_in;
         prod_p_ff <= prod_p_in;
         neg_ff    <= neg_in;
         over_ff   <= over_in;
      end
   end

   assign diff     = $signed({1'b0, prod_s_ff}) - $signed({1'b0, prod_p_ff});
   assign diff_abs = diff[msp_pkg::PROD_W] ? (msp_pkg::PROD_W+1)'(-diff)
                                           : (msp_pkg::PROD_W+1)'(diff);

   always_comb begin
      flags_in.neg  = neg_ff;
      flags_in.over = over_ff;
      flags_in.mism = diff_abs > slack;
   end

   always_ff @(posedge clock) begin
      if (load_b) begin
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule

`default_nettype wire

FILE: hdl/msp_merge.sv
`default_nettype none

// Scans lane flags up to the first reversed motor, runs the persistence
// counters and holds the result beat.
module msp_merge (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output      logic                          in_ready,
   input  wire msp_pkg::lane_flags_type       lane_flags [msp_pkg::MOTOR_COUNT],
   input  wire logic [msp_pkg::TICKS_W-1:0]   overspeed_ticks,
   input  wire logic [msp_pkg::TICKS_W-1:0]   mismatch_ticks,
   msp_rsp_if.source                          rsp
);

   logic                          dir_fault, any_over, any_mism, seen_neg;
   logic [msp_pkg::TICKS_W-1:0]   os_cnt_ff, os_cnt_in, os_step;
   logic [msp_pkg::TICKS_W-1:0]   mm_cnt_ff, mm_cnt_in, mm_step;
   logic                          os_hit, mm_hit;
   logic                          valid_ff, valid_in;
   logic                          s_rep_ff, s_rep_in, s_dan_ff, s_dan_in;
   logic                          p_rep_ff, p_rep_in, p_dan_ff, p_dan_in;
   logic                          take;

   always_comb begin
      seen_neg = 1'b0;
      any_over = 1'b0;
      any_mism = 1'b0;
      for (int i = 0; i < msp_pkg::MOTOR_COUNT; i++) begin
         if (!seen_neg) begin
            if (lane_flags[i].neg) begin
               seen_neg = 1'b1;
            end else begin
               any_over = any_over | lane_flags[i].over;
               any_mism = any_mism | lane_flags[i].mism;
            end
         end
      end
      dir_fault = seen_neg;
   end

   // saturating step; a tick count of 0 fires like 1
   assign os_step = (os_cnt_ff == '1) ? os_cnt_ff : os_cnt_ff + 1'b1;
   assign mm_step = (mm_cnt_ff == '1) ? mm_cnt_ff : mm_cnt_ff + 1'b1;
   assign os_hit  = os_step >= overspeed_ticks;
   assign mm_hit  = mm_step >= mismatch_ticks;

   assign in_ready = !valid_ff || rsp.ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      os_cnt_in = os_cnt_ff;
      s_rep_in  = 1'b0;
      s_dan_in  = 1'b0;
      priority if (dir_fault) begin
         s_rep_in = 1'b1;
         s_dan_in = 1'b1;
      end else if (any_over) begin
         os_cnt_in = os_hit ? '0 : os_step;
         s_rep_in  = os_hit;
         s_dan_in  = os_hit;
      end else begin
         os_cnt_in = '0;
         s_rep_in  = 1'b1;
      end

      if (any_mism) begin
         mm_cnt_in = mm_hit ? '0 : mm_step;
         p_rep_in  = mm_hit;
         p_dan_in  = mm_hit;
      end else begin
         mm_cnt_in = '0;
         p_rep_in  = 1'b1;
         p_dan_in  = 1'b0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         os_cnt_ff <= '0;
         mm_cnt_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            os_cnt_ff <= os_cnt_in;
            mm_cnt_ff <= mm_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s_rep_ff <= s_rep_in;
         s_dan_ff <= s_dan_in;
         p_rep_ff <= p_rep_in;
         p_dan_ff <= p_dan_in;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.speed_report = s_rep_ff;
   assign rsp.speed_danger = s_dan_ff;
   assign rsp.power_report = p_rep_ff;
   assign rsp.power_danger = p_dan_ff;

endmodule

`default_nettype wire
